// ----- hdl/hds_pkg.sv -----
// ----------------------------------------------------------------------------
// hds_pkg
// Shared constants, register codes and types of the heat diffusion stencil.
// ----------------------------------------------------------------------------
package hds_pkg;

  // Line buffer geometry
  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned COL_W       = $clog2(MAX_COLS);
  localparam int unsigned MIN_DIM     = 3;

  // Field widths
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned GRID_COLS_W = 11;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned LINE_W      = 2 * SAMPLE_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [COEF_W-1:0]      COEF_RESET      = 16'd6554;
  localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 11'd8;
  localparam logic [ROW_W-1:0]       GRID_ROWS_RESET = 16'd8;

  // Arithmetic widths: Q16.16 samples, Q0.16 weights
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DIFF_W  = SAMPLE_W + 2;
  localparam int unsigned PROD_W  = COEF_W + 1 + DIFF_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam int unsigned DELTA_W = ACC_W - FRAC_W;
  localparam int unsigned SUM_W   = DELTA_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_ROW,
    CFG_COEF_COL,
    CFG_GRID_COLS,
    CFG_GRID_ROWS
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_PRIME_CUR,
    FS_PRIME_NXT,
    FS_RUN
  } front_state_e;

  typedef struct packed {
    logic [COEF_W-1:0] row_w;
    logic [COEF_W-1:0] col_w;
  } hds_coef_t;

  // One classified sample, as passed from the front to the back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] down;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                has_a;
    logic                a_pass;
    logic                has_b;
    logic                b_end;
  } hds_job_t;

endpackage

// ----- hdl/hds_if.sv -----
// ----------------------------------------------------------------------------
// hds_if
// Valid/ready channels for grid samples and for stencil results.
// ----------------------------------------------------------------------------
interface hds_in_if import hds_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hds_out_if import hds_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] value;
  logic [ROW_W-1:0]           row_index;
  logic [COL_W-1:0]           col_index;
  logic                       frame_end;

  modport source (output valid, output value, output row_index, output col_index,
                  output frame_end, input ready);
  modport sink   (input valid, input value, input row_index, input col_index,
                  input frame_end, output ready);
endinterface

// ----- hdl/heat_diffusion_stencil_top.sv -----
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_top
// One explicit time step of 2D heat diffusion with a five-point stencil over
// a grid streamed in raster order.
// ----------------------------------------------------------------------------
// Usage. Samples (signed Q16.16) enter on samp_i in raster order, one
// transaction each; results leave on res_o with their row and column, and
// frame_end marks the final result of the grid. Receiving a sample of row r
// releases the result for row r-1 in the same column; samples of row 0 give
// no result, and samples of the last row give two: the stencil result of
// the row above, then the sample itself unchanged.
// Throughput is one sample per cycle while res_o keeps up, set by the
// single read and single write port of the line buffer RAM; in the last
// row the output channel carries two transactions per sample, so samples
// there are taken only as fast as both results leave. From acceptance, a
// result passes the queue, difference, multiply, rounding and output stages.
// After reset the line buffer is swept to zero over all 1024 words, then the
// first buffer words are prefetched; samp_i.ready stays low meanwhile.
// A write to grid_cols repeats the prefetch. When res_o stalls, the pipeline
// and a two-entry queue fill before samp_i.ready drops.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// and must only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_top import hds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hds_in_if.sink                samp_i,
  hds_out_if.source             res_o
);

  // Front to queue, and queue to back end
  logic      push_valid, push_ready, pop_valid, pop_ready;
  hds_job_t  push_job, pop_job;
  hds_coef_t coef;

  // The front end owns the counters and the line buffer; it classifies each
  // sample and forwards only those that produce at least one result.
  hds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .samp_i       (samp_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job),
    .coef_o       (coef)
  );

  // The queue lets the back end stall on the output without freezing the
  // line buffer sequencing on the same cycle.
  hds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // The back end does all the arithmetic and the result sequencing.
  hds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .job_i       (pop_job),
    .coef_i      (coef),
    .res_o       (res_o)
  );

endmodule

// ----- hdl/hds_ram.sv -----
// ----------------------------------------------------------------------------
// hds_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/hds_front.sv -----
// ----------------------------------------------------------------------------
// hds_front
// Configuration registers, raster counters and line buffer. Accepts samples,
// gathers the five stencil operands and classifies each sample's results.
// ----------------------------------------------------------------------------
module hds_front import hds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hds_in_if.sink                samp_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output hds_job_t              push_job_o,
  output hds_coef_t             coef_o
);

  logic [COEF_W-1:0]      coef_row_q, coef_col_q;
  logic [GRID_COLS_W-1:0] grid_cols_q;
  logic [ROW_W-1:0]       grid_rows_q;

  front_state_e state_q, state_d;
  logic [COL_W-1:0]    clr_q, clr_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [SAMPLE_W-1:0] left_q;
  logic [LINE_W-1:0]   cur_q;

  logic [GRID_COLS_W-1:0] cols_eff, cols_m1;
  logic [ROW_W-1:0]       rows_eff;
  logic [COL_W-1:0]       c_eff, c_next, c_after;
  logic                   last_col, last_row, cols_wr, accept, cur_load;

  logic              ram_we, ram_re;
  logic [COL_W-1:0]  ram_waddr, ram_raddr;
  logic [LINE_W-1:0] ram_wdata, ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_row_q  <= COEF_RESET;
      coef_col_q  <= COEF_RESET;
      grid_cols_q <= GRID_COLS_RESET;
      grid_rows_q <= GRID_ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_COEF_ROW:  coef_row_q  <= cfg_wdata_i[COEF_W-1:0];
        CFG_COEF_COL:  coef_col_q  <= cfg_wdata_i[COEF_W-1:0];
        CFG_GRID_COLS: grid_cols_q <= cfg_wdata_i[GRID_COLS_W-1:0];
        CFG_GRID_ROWS: grid_rows_q <= cfg_wdata_i[ROW_W-1:0];
      endcase
    end
  end

  assign coef_o.row_w = coef_row_q;
  assign coef_o.col_w = coef_col_q;
  assign cols_wr = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_GRID_COLS);

  // Effective grid size and current position
  always_comb begin
    if (grid_cols_q < GRID_COLS_W'(MIN_DIM)) begin
      cols_eff = GRID_COLS_W'(MIN_DIM);
    end else if (grid_cols_q > GRID_COLS_W'(MAX_COLS)) begin
      cols_eff = GRID_COLS_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
    if (grid_rows_q < ROW_W'(MIN_DIM)) begin
      rows_eff = ROW_W'(MIN_DIM);
    end else begin
      rows_eff = grid_rows_q;
    end
  end

  assign cols_m1  = cols_eff - GRID_COLS_W'(1);
  assign c_eff    = (GRID_COLS_W'(col_q) >= cols_eff) ? cols_m1[COL_W-1:0] : col_q;
  assign last_col = (GRID_COLS_W'(c_eff) == cols_m1);
  assign last_row = (row_q >= rows_eff - ROW_W'(1));
  assign c_next   = last_col ? '0 : c_eff + COL_W'(1);
  assign c_after  = (GRID_COLS_W'(c_next) == cols_m1) ? '0 : c_next + COL_W'(1);

  assign samp_i.ready = (state_q == FS_RUN) && push_ready_i;
  assign accept       = samp_i.valid && samp_i.ready;

  // Sequencer: clearing sweep, line buffer prefetch, streaming
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = c_eff;
    ram_wdata = {samp_i.sample, cur_q[LINE_W-1:SAMPLE_W]};
    ram_re    = 1'b0;
    ram_raddr = c_eff;
    unique case (state_q)
      FS_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + COL_W'(1);
        if (clr_q == COL_W'(MAX_COLS - 1)) begin
          state_d = FS_PRIME_CUR;
        end
      end
      FS_PRIME_CUR: begin
        ram_re  = 1'b1;
        state_d = cols_wr ? FS_PRIME_CUR : FS_PRIME_NXT;
      end
      FS_PRIME_NXT: begin
        cur_load  = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = c_next;
        state_d   = cols_wr ? FS_PRIME_CUR : FS_RUN;
      end
      FS_RUN: begin
        if (accept) begin
          cur_load  = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = c_after;
          ram_we    = 1'b1;
        end
        if (cols_wr) begin
          state_d = FS_PRIME_CUR;
        end
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = c_eff + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_CLEAR;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (accept) begin
        left_q <= cur_q[LINE_W-1:SAMPLE_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_q <= ram_rdata;
    end
  end

  // Each word holds the previous row (upper half) and the row before it.
  hds_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    push_job_o.u      = cur_q[LINE_W-1:SAMPLE_W];
    push_job_o.up     = cur_q[SAMPLE_W-1:0];
    push_job_o.down   = samp_i.sample;
    push_job_o.left   = left_q;
    push_job_o.right  = last_col ? '0 : ram_rdata[LINE_W-1:SAMPLE_W];
    push_job_o.row    = row_q;
    push_job_o.col    = c_eff;
    push_job_o.has_a  = (row_q != '0);
    push_job_o.a_pass = (row_q == ROW_W'(1)) || (c_eff == '0) || last_col;
    push_job_o.has_b  = last_row;
    push_job_o.b_end  = last_col;
  end

  assign push_valid_o = accept && ((row_q != '0) || last_row);

endmodule

// ----- hdl/hds_queue.sv -----
// ----------------------------------------------------------------------------
// hds_queue
// Short FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module hds_queue import hds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  hds_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output hds_job_t pop_job_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  hds_job_t          slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- hdl/hds_back.sv -----
// ----------------------------------------------------------------------------
// hds_back
// Stencil arithmetic pipeline and result register. Forms the two second
// differences, weights them, rounds and saturates, then emits one or two
// result transactions per job.
// ----------------------------------------------------------------------------
module hds_back import hds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  hds_job_t  job_i,
  input  hds_coef_t coef_i,
  hds_out_if.source res_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] down;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                has_a;
    logic                a_pass;
    logic                has_b;
    logic                b_end;
  } meta_t;

  logic s1_v_q, s2_v_q, s3_v_q, out_v_q, phase_q;
  logic s1_ready, s2_ready, s3_ready, out_free, show_a, out_last, res_fire;

  meta_t s1_meta_q, s2_meta_q, s3_meta_q, out_meta_q, job_meta;
  logic signed [DIFF_W-1:0]  u_x, dr, dc, s1_dr_q, s1_dc_q;
  logic signed [PROD_W-1:0]  prod_r, prod_c, s2_pr_q, s2_pc_q;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DELTA_W-1:0] s3_delta_q;
  logic signed [SUM_W-1:0]   sum;
  logic [SAMPLE_W-1:0]       sat_val, val_a, out_val_a_q;

  // Handshake chain: a stage loads when it is empty or its content moves on
  assign res_fire    = res_o.valid && res_o.ready;
  assign show_a      = out_meta_q.has_a && !phase_q;
  assign out_last    = show_a ? !out_meta_q.has_b : 1'b1;
  assign out_free    = !out_v_q || (res_o.ready && out_last);
  assign s3_ready    = !s3_v_q || out_free;
  assign s2_ready    = !s2_v_q || s3_ready;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign pop_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= pop_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
      if (out_free) begin
        out_v_q <= s3_v_q;
        phase_q <= 1'b0;
      end else if (res_fire) begin
        phase_q <= 1'b1;
      end
    end
  end

  // Stage 1: second differences along rows and columns
  always_comb begin
    job_meta.u      = job_i.u;
    job_meta.down   = job_i.down;
    job_meta.row    = job_i.row;
    job_meta.col    = job_i.col;
    job_meta.has_a  = job_i.has_a;
    job_meta.a_pass = job_i.a_pass;
    job_meta.has_b  = job_i.has_b;
    job_meta.b_end  = job_i.b_end;
  end

  assign u_x = DIFF_W'(signed'(job_i.u));
  assign dr  = DIFF_W'(signed'(job_i.up)) + DIFF_W'(signed'(job_i.down)) - (u_x <<< 1);
  assign dc  = DIFF_W'(signed'(job_i.left)) + DIFF_W'(signed'(job_i.right)) - (u_x <<< 1);

  // Stage 2: weighting by the unsigned Q0.16 coefficients
  assign prod_r = $signed({1'b0, coef_i.row_w}) * s1_dr_q;
  assign prod_c = $signed({1'b0, coef_i.col_w}) * s1_dc_q;

  // Stage 3: sum and round half up to Q16.16
  assign acc = ACC_W'(s2_pr_q) + ACC_W'(s2_pc_q) + (ACC_W'(1) <<< (FRAC_W - 1));

  // Result: add the change and saturate to the 32-bit range
  assign sum = SUM_W'(signed'(s3_meta_q.u)) + SUM_W'(s3_delta_q);

  always_comb begin
    if ((&sum[SUM_W-1:SAMPLE_W-1]) || !(|sum[SUM_W-1:SAMPLE_W-1])) begin
      sat_val = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    val_a = s3_meta_q.a_pass ? s3_meta_q.u : sat_val;
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && pop_valid_i) begin
      s1_dr_q   <= dr;
      s1_dc_q   <= dc;
      s1_meta_q <= job_meta;
    end
    if (s2_ready && s1_v_q) begin
      s2_pr_q   <= prod_r;
      s2_pc_q   <= prod_c;
      s2_meta_q <= s1_meta_q;
    end
    if (s3_ready && s2_v_q) begin
      s3_delta_q <= DELTA_W'(acc >>> FRAC_W);
      s3_meta_q  <= s2_meta_q;
    end
    if (out_free && s3_v_q) begin
      out_val_a_q <= val_a;
      out_meta_q  <= s3_meta_q;
    end
  end

  // The stencil result of the row above goes first, the last-row copy second.
  assign res_o.valid     = out_v_q;
  assign res_o.value     = show_a ? signed'(out_val_a_q) : signed'(out_meta_q.down);
  assign res_o.row_index = show_a ? out_meta_q.row - ROW_W'(1) : out_meta_q.row;
  assign res_o.col_index = out_meta_q.col;
  assign res_o.frame_end = show_a ? 1'b0 : out_meta_q.b_end;

endmodule

// ----- sim/tb_heat_diffusion_stencil_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heat_diffusion_stencil_top
// Self-checking bench for one explicit heat diffusion step over a streamed
// grid. Samples go in, and the new temperatures are predicted in step with
// every accepted sample and compared field by field with what comes out.
// ----------------------------------------------------------------------------
module tb_heat_diffusion_stencil_top;
  import hds_pkg::*;

  // Stimulus volume and time limits. The watchdog must cover the line buffer
  // clearing pass after reset and the prefetch that follows, with ample margin.
  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned STUCK_LIMIT   = 5000;

  localparam logic signed [SAMPLE_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] TEMP_MIN = 32'sh8000_0000;

  // One new temperature as it should leave the block.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic                       frame_end;
  } temp_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hds_in_if  samp_if ();
  hds_out_if res_if ();

  heat_diffusion_stencil_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .samp_i      (samp_if),
    .res_o       (res_if)
  );

  // --------------------------------------------------------------------------
  // Shadow of the grid as the block should see it: both line buffers, the
  // held left neighbour, the raster position and the four registers.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] row_above_buf  [MAX_COLS];
  logic signed [SAMPLE_W-1:0] row_two_up_buf [MAX_COLS];
  logic signed [SAMPLE_W-1:0] held_left;
  int unsigned                at_row;
  int unsigned                at_col;
  logic [COEF_W-1:0]          w_row;
  logic [COEF_W-1:0]          w_col;
  logic [GRID_COLS_W-1:0]     cols_reg;
  logic [ROW_W-1:0]           rows_reg;

  // New temperatures still owed by the block, oldest first.
  temp_result_t               temps_due [$];
  // Samples waiting to be offered on the input channel.
  logic signed [SAMPLE_W-1:0] sample_q [$];

  temp_result_t want_temp;
  int unsigned  err_count;
  int unsigned  n_samples;
  int unsigned  n_results;
  int unsigned  n_frames;
  int unsigned  n_phases;
  int unsigned  stuck_cycles;

  // Idling controls; each side draws a fresh wait per transaction when on.
  bit           feed_gaps_on;
  bit           drain_stalls_on;
  int unsigned  feed_wait;
  int unsigned  res_stall;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Column count in use: the register clamped to at least three and at most the line buffer size.
  function automatic int unsigned eff_cols();
    int unsigned n;
    n = cols_reg;
    if (n < MIN_DIM) n = MIN_DIM;
    if (n > MAX_COLS) n = MAX_COLS;
    return n;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned n;
    n = rows_reg;
    if (n < MIN_DIM) n = MIN_DIM;
    return n;
  endfunction

  // Samples still needed to close the current frame from where the raster
  // position stands now, taking a shrunk grid into account.
  function automatic int unsigned samples_to_frame_end();
    int unsigned cols, rows, c, rows_left;
    cols = eff_cols();
    rows = eff_rows();
    c = (at_col >= cols) ? cols - 1 : at_col;
    rows_left = (at_row >= rows - 1) ? 0 : rows - 1 - at_row;
    return rows_left * cols + cols - c;
  endfunction

  // Five-point update of one interior cell. The weighted sums are exact in
  // 64 bits (Q32.32), rounded half up back to Q16.16, then the new value is
  // clamped to the 32-bit range.
  function automatic logic signed [SAMPLE_W-1:0] diffused_value(
    input logic signed [SAMPLE_W-1:0] u,
    input logic signed [SAMPLE_W-1:0] up,
    input logic signed [SAMPLE_W-1:0] dn,
    input logic signed [SAMPLE_W-1:0] lf,
    input logic signed [SAMPLE_W-1:0] rt
  );
    longint lu, d_row, d_col, kr, kc, acc, delta, total;
    lu    = u;
    kr    = w_row;
    kc    = w_col;
    d_row = longint'(up) + longint'(dn) - 2 * lu;
    d_col = longint'(lf) + longint'(rt) - 2 * lu;
    acc   = kr * d_row + kc * d_col;
    delta = (acc + 64'sd32768) >>> FRAC_W;
    total = lu + delta;
    if (total > longint'(TEMP_MAX)) total = longint'(TEMP_MAX);
    if (total < longint'(TEMP_MIN)) total = longint'(TEMP_MIN);
    return total[SAMPLE_W-1:0];
  endfunction

  // Accounts for one accepted sample: queues the temperature of the cell one
  // row up in the same column, and on the last row the sample itself as well.
  function automatic void advance_stencil(input logic signed [SAMPLE_W-1:0] s);
    int unsigned                cols, rows, c, r;
    logic signed [SAMPLE_W-1:0] centre, above, right_nb, new_v;
    bit                         last_col, last_row;
    cols = eff_cols();
    rows = eff_rows();
    c = (at_col >= cols) ? cols - 1 : at_col;
    r = at_row;
    last_col = (c >= cols - 1);
    last_row = (r >= rows - 1);

    centre   = row_above_buf[c];
    above    = row_two_up_buf[c];
    right_nb = last_col ? '0 : row_above_buf[c+1];

    if (r >= 1) begin
      // The top row and the outer columns keep their old temperature.
      if (r == 1 || c == 0 || last_col) begin
        new_v = centre;
      end else begin
        new_v = diffused_value(centre, above, s, held_left, right_nb);
      end
      temps_due.push_back('{new_v, ROW_W'(r - 1), COL_W'(c), 1'b0});
    end
    if (last_row) begin
      temps_due.push_back('{s, ROW_W'(r), COL_W'(c), last_col});
    end

    row_two_up_buf[c] = centre;
    held_left         = centre;
    row_above_buf[c]  = s;

    if (last_col) begin
      at_col = 0;
      at_row = last_row ? 0 : (r + 1) & 32'hFFFF;
    end else begin
      at_col = (c + 1) & 32'h3FF;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] extreme_sample(input int unsigned k);
    case (k)
      0:       return TEMP_MAX;
      1:       return TEMP_MIN;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      5:       return 32'sh0001_0000;
      6:       return 32'sh5555_5555;
      default: return 32'shAAAA_AAAA;
    endcase
  endfunction

  // Sample content styles: full range, gentle temperatures near zero, the
  // corner values, and values hugging either rail so that clamping occurs.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned style);
    case (style)
      0:       return $urandom;
      1:       return int'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      2:       return extreme_sample($urandom_range(0, 7));
      default: return $urandom_range(0, 1) ? TEMP_MAX - $urandom_range(0, 4095)
                                           : TEMP_MIN + $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return COEF_RESET;
      3:       return COEF_W'($urandom_range(32768, 65535));
      default: return COEF_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int unsigned gap_draw(input bit on);
    return on ? $urandom_range(0, 8) : 0;
  endfunction

  // Register write through the plain configuration port. The shadow copy is
  // updated once the block has taken the write.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_COEF_ROW:  w_row    = data;
      CFG_COEF_COL:  w_col    = data;
      CFG_GRID_COLS: cols_reg = data[GRID_COLS_W-1:0];
      CFG_GRID_ROWS: rows_reg = data;
      default: ;
    endcase
  endtask

  // Queues a phase worth of samples. Filling happens on the falling edge so
  // that the driver sees the whole phase at one well-defined clock edge.
  task automatic queue_samples(input int unsigned count, input int unsigned style);
    @(negedge clk_i);
    for (int unsigned i = 0; i < count; i++) begin
      sample_q.push_back(pick_sample(style == 4 ? $urandom_range(0, 3) : style));
    end
    n_phases++;
  endtask

  // Waits until every queued sample has been taken and every owed result has
  // arrived, then lets the pipeline run dry. Samples of the first row leave
  // nothing behind to wait for, hence the extra cycles.
  task automatic drain_phase();
    while (!(sample_q.size() == 0 && !samp_if.valid && temps_due.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Input driver: offers queued samples, holding each until its transaction
  // completes, then idles for the gap drawn for the next sample.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_if.valid  <= 1'b0;
      samp_if.sample <= '0;
      feed_wait      <= 0;
    end else if (!samp_if.valid || samp_if.ready) begin
      if (feed_wait != 0) begin
        samp_if.valid <= 1'b0;
        feed_wait     <= feed_wait - 1;
      end else if (sample_q.size() != 0) begin
        samp_if.valid  <= 1'b1;
        samp_if.sample <= sample_q.pop_front();
        feed_wait      <= gap_draw(feed_gaps_on);
      end else begin
        samp_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: when stalls are on, a stall is drawn after each
  // transaction, during which ready stays low.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_stall    <= 0;
    end else if (res_if.valid && res_if.ready) begin
      res_stall    <= gap_draw(drain_stalls_on);
      res_if.ready <= !drain_stalls_on;
    end else if (res_stall != 0) begin
      res_stall    <= res_stall - 1;
      res_if.ready <= (res_stall == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted sample and checks every accepted
  // result against the oldest owed temperature. Prediction runs first, though
  // no result can leave in the cycle its sample is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (samp_if.valid && samp_if.ready) begin
        advance_stencil(samp_if.sample);
        n_samples++;
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (res_if.frame_end === 1'b1) n_frames++;
        if (temps_due.size() == 0) begin
          $error("result at row %0d col %0d arrived with none owed",
                 res_if.row_index, res_if.col_index);
          err_count++;
        end else begin
          want_temp = temps_due.pop_front();
          if (res_if.value !== want_temp.value) begin
            $error("value: expected %h, got %h (row %0d col %0d)",
                   want_temp.value, res_if.value, want_temp.row, want_temp.col);
            err_count++;
          end
          if (res_if.row_index !== want_temp.row) begin
            $error("row_index: expected %0d, got %0d", want_temp.row, res_if.row_index);
            err_count++;
          end
          if (res_if.col_index !== want_temp.col) begin
            $error("col_index: expected %0d, got %0d", want_temp.col, res_if.col_index);
            err_count++;
          end
          if (res_if.frame_end !== want_temp.frame_end) begin
            $error("frame_end: expected %0b, got %0b (row %0d col %0d)",
                   want_temp.frame_end, res_if.frame_end, want_temp.row, want_temp.col);
            err_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which neither channel completes a transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: %0d cycles without a transaction, %0d results still owed",
               stuck_cycles, temps_due.size());
      $display("heat_diffusion_stencil_top: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rnd_total;
    int unsigned count;
    int unsigned gc;
    int unsigned gr;

    // Every block input is known from time zero.
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_COEF_ROW;
    cfg_wdata      = '0;
    samp_if.valid  = 1'b0;
    samp_if.sample = '0;
    res_if.ready   = 1'b0;

    // Shadow state after reset: empty line buffers, registers at reset value.
    for (int i = 0; i < MAX_COLS; i++) begin
      row_above_buf[i]  = '0;
      row_two_up_buf[i] = '0;
    end
    held_left       = '0;
    at_row          = 0;
    at_col          = 0;
    w_row           = COEF_RESET;
    w_col           = COEF_RESET;
    cols_reg        = GRID_COLS_RESET;
    rows_reg        = GRID_ROWS_RESET;
    err_count       = 0;
    n_samples       = 0;
    n_results       = 0;
    n_frames        = 0;
    n_phases        = 0;
    stuck_cycles    = 0;
    rnd_total       = 0;
    feed_gaps_on    = 1'b0;
    drain_stalls_on = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: nine samples at the reset grid size of eight columns. Row 0
    // gives nothing back; the ninth sample opens row 1 and releases the
    // top-left border cell, which checks the reset column count.
    @(negedge clk_i);
    for (int unsigned k = 0; k < 9; k++) sample_q.push_back(extreme_sample(k % 8));
    n_phases++;
    drain_phase();

    // Directed: shrink to 3 by 3 in mid-row. The column position is still
    // inside the new width, so two more samples close row 1; row 2 is now the
    // last row, so each of its samples returns two results, and its middle
    // sample releases the first true stencil update, with the reset weights.
    write_reg(CFG_GRID_COLS, 16'd3);
    write_reg(CFG_GRID_ROWS, 16'd3);
    @(negedge clk_i);
    sample_q.push_back(TEMP_MIN);
    sample_q.push_back(TEMP_MAX);
    sample_q.push_back(32'sh0003_8000);
    sample_q.push_back(TEMP_MIN);
    n_phases++;
    drain_phase();

    // Directed: full weights. The first sample closes the frame in progress;
    // in the next one a cold centre is ringed by the hottest value, so the
    // update overshoots and must clamp at the top rail.
    write_reg(CFG_COEF_ROW, '1);
    write_reg(CFG_COEF_COL, '1);
    @(negedge clk_i);
    for (int unsigned k = 0; k < 9; k++) sample_q.push_back(k == 5 ? '0 : TEMP_MAX);
    n_phases++;
    drain_phase();

    // The widest grid: a column count above the buffer size is clamped to
    // 1024, and a zero row count to three, which makes the current row the
    // last. The rest of that frame is streamed with idling on both sides.
    feed_gaps_on    = 1'b1;
    drain_stalls_on = 1'b1;
    write_reg(CFG_COEF_ROW, pick_coef());
    write_reg(CFG_COEF_COL, pick_coef());
    write_reg(CFG_GRID_COLS, 16'h07FF);
    write_reg(CFG_GRID_ROWS, 16'd0);
    queue_samples(samples_to_frame_end(), 4);
    drain_phase();

    // Exactly 1024 columns and the tallest grid; only part of one row goes through,
    // and the random part then resizes the grid under a frame in progress.
    write_reg(CFG_GRID_COLS, 16'd1024);
    write_reg(CFG_GRID_ROWS, 16'hFFFF);
    queue_samples($urandom_range(20, 60), 0);
    drain_phase();

    // Random phases. Most run to the end of the frame and on through whole
    // frames; the rest stop in mid-frame so that the next resize lands on a
    // partly streamed grid.
    while (rnd_total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) write_reg(CFG_COEF_ROW, pick_coef());
      if ($urandom_range(0, 1)) write_reg(CFG_COEF_COL, pick_coef());
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       gc = $urandom_range(0, 2);
          1:       gc = $urandom_range(13, 48);
          default: gc = $urandom_range(3, 12);
        endcase
        write_reg(CFG_GRID_COLS, 16'(gc));
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 15))
          0:       gr = 16'hFFFF;
          1, 2:    gr = $urandom_range(0, 2);
          default: gr = $urandom_range(3, 7);
        endcase
        write_reg(CFG_GRID_ROWS, 16'(gr));
      end
      feed_gaps_on    = ($urandom_range(0, 3) != 0);
      drain_stalls_on = ($urandom_range(0, 3) != 0);

      if (eff_rows() <= 64 && $urandom_range(0, 3) != 0) begin
        count = samples_to_frame_end() + $urandom_range(0, 2) * eff_cols() * eff_rows();
      end else begin
        count = $urandom_range(1, 2 * eff_cols() + 3);
      end
      // Keep the overall sample count near the intended volume.
      if (count > RANDOM_ITEMS - rnd_total) count = RANDOM_ITEMS - rnd_total;
      queue_samples(count, $urandom_range(0, 4));
      rnd_total += count;
      drain_phase();
    end

    if (temps_due.size() != 0) begin
      $error("%0d results never arrived", temps_due.size());
      err_count++;
    end

    $display("covered %0d samples in %0d phases, %0d results checked, %0d grids completed",
             n_samples, n_phases, n_results, n_frames);
    if (err_count == 0) begin
      $display("heat_diffusion_stencil_top: match");
    end else begin
      $display("%0d checks failed", err_count);
      $display("heat_diffusion_stencil_top: mismatch");
    end
    $finish;
  end

endmodule
